// ===== rtl/rc4sc_pkg.sv =====
// RC4 cipher block: shared types and constants.
// No dependencies; imported by rc4_stream_cipher.
package rc4sc_pkg;

	// Number of key bytes that complete the key schedule (1..256)
	localparam logic [8:0] KEY_LENGTH = 9'd256;

	// Command codes carried on cmd
	typedef enum logic [1:0] {
		CMD_KEY     = 2'd0,
		CMD_DATA    = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RDJ  = 5'b00010,
		ST_WRI  = 5'b00100,
		ST_WRJ  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

endpackage

// ===== rtl/rc4_stream_cipher.sv =====
// RC4 cipher block top level: sequencer around the 256-entry permutation memory.
// Depends on rc4sc_pkg.
//
// One word goes in per item. A key word (cmd 0) runs one key-scheduling step through
// states RDJ, WRI and WRJ before the next acceptance; a data word (cmd 1) runs one
// keystream step through RDJ, WRI, WRJ and OUT, its result landing in an output register
// that may wait for the consumer while the next item is taken. A data word sent before
// the key is complete passes through OUT unchanged with key_incomplete set. Restart
// (cmd 2) and the unused code stay in IDLE; restart restores the identity permutation
// at once through per-entry valid bits. The sequence is set by the permutation memory,
// which has one read port and one write port: each step reads two entries, writes them
// back swapped, and reads the keystream entry, one access per port per cycle.
module rc4_stream_cipher
	import rc4sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] byte_in,
	input  logic       last_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic       last_out,
	output logic       key_incomplete
);

	// Control state
	state_t      state_q;
	logic [7:0]  i_q;
	logic [7:0]  j_q;
	logic [8:0]  cnt_q;
	logic [255:0] valid_q;
	logic        ovalid_q;

	// Per-item working registers
	logic        is_key_q;
	logic        pass_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [7:0]  ai_q;
	logic [7:0]  jn_q;
	logic [7:0]  si_q;
	logic [7:0]  sj_q;

	// Memory and read path
	logic [7:0]  mem [256];
	logic [7:0]  rdata_q;
	logic        rvld_q;
	logic [7:0]  raddr_q;
	logic [7:0]  raddr;
	logic        we;
	logic [7:0]  waddr;
	logic [7:0]  wdata;
	logic [7:0]  rd;

	// Output register
	logic [7:0]  obyte_q;
	logic        olast_q;
	logic        oinc_q;

	logic        accept;
	logic        key_done;
	logic [7:0]  i_inc;
	logic [7:0]  ai_next;
	logic [7:0]  kadd;
	logic [9:0]  jsum;
	logic [8:0]  tsum;
	logic [8:0]  cnt_inc;
	logic        out_free;
	logic [7:0]  ks;
	cmd_t        cmd_c;

	assign cmd_c    = cmd_t'(cmd);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign key_done = (cnt_q >= KEY_LENGTH);
	assign out_free = !ovalid_q || out_ready;

	// Table read: an entry never written reads as its own index
	assign rd = rvld_q ? rdata_q : raddr_q;

	// Index arithmetic, all modulo 256
	assign i_inc   = 8'(i_q + 8'd1);
	assign ai_next = (cmd_c == CMD_DATA) ? i_inc : i_q;
	assign kadd    = is_key_q ? byte_q : 8'd0;
	assign jsum    = {2'b00, j_q} + {2'b00, rd} + {2'b00, kadd};
	assign tsum    = {1'b0, si_q} + {1'b0, sj_q};
	assign cnt_inc = cnt_q + 9'd1;

	// Keystream byte: forward S[j] when t hits the entry written last cycle
	assign ks = (raddr_q == jn_q) ? si_q : rd;

	// Memory port control
	always_comb begin
		raddr = ai_next;
		we    = 1'b0;
		waddr = ai_q;
		wdata = rd;
		case (state_q)
			ST_IDLE: begin
				raddr = ai_next;
			end
			ST_RDJ: begin
				raddr = jsum[7:0];
			end
			ST_WRI: begin
				we    = 1'b1;
				waddr = ai_q;
				wdata = rd;
			end
			ST_WRJ: begin
				we    = 1'b1;
				waddr = jn_q;
				wdata = si_q;
				raddr = tsum[7:0];
			end
			ST_OUT: begin
				// keep the keystream entry on the read port while the result waits
				raddr = raddr_q;
			end
			default: begin
				raddr = ai_next;
			end
		endcase
	end

	// Permutation memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
		raddr_q <= raddr;
	end

	// Valid bit of the entry being read, sampled with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= valid_q[raddr];
		end
	end

	// Sequencer and running indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= 8'd0;
			j_q     <= 8'd0;
			cnt_q   <= 9'd0;
			valid_q <= '0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd_c)
							CMD_KEY: begin
								if (!key_done) begin
									state_q <= ST_RDJ;
								end
							end
							CMD_DATA: begin
								state_q <= key_done ? ST_RDJ : ST_OUT;
							end
							CMD_RESTART: begin
								valid_q <= '0;
								i_q     <= 8'd0;
								j_q     <= 8'd0;
								cnt_q   <= 9'd0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RDJ: begin
					state_q <= ST_WRI;
				end
				ST_WRI: begin
					state_q <= ST_WRJ;
				end
				ST_WRJ: begin
					if (is_key_q) begin
						cnt_q <= cnt_inc;
						if (cnt_inc >= KEY_LENGTH) begin
							i_q <= 8'd0;
							j_q <= 8'd0;
						end else begin
							i_q <= 8'(ai_q + 8'd1);
							j_q <= jn_q;
						end
						state_q <= ST_IDLE;
					end else begin
						i_q     <= ai_q;
						j_q     <= jn_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Per-item working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			is_key_q <= (cmd_c == CMD_KEY);
			pass_q   <= !key_done;
			byte_q   <= byte_in;
			last_q   <= last_in;
			ai_q     <= ai_next;
		end
		if (state_q == ST_RDJ) begin
			si_q <= rd;
			jn_q <= jsum[7:0];
		end
		if (state_q == ST_WRI) begin
			sj_q <= rd;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			obyte_q <= pass_q ? byte_q : (byte_q ^ ks);
			olast_q <= last_q;
			oinc_q  <= pass_q;
		end
	end

	assign out_valid      = ovalid_q;
	assign byte_out       = obyte_q;
	assign last_out       = olast_q;
	assign key_incomplete = oinc_q;

	// Restart clears the key count and indices
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_c == CMD_RESTART |=> cnt_q == 9'd0 && i_q == 8'd0 && j_q == 8'd0)
		else $error("restart did not clear the key state");

	// Key completion leaves both indices at zero
	a_keydone: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(key_done) |-> i_q == 8'd0 && j_q == 8'd0)
		else $error("indices not cleared at key completion");

	// The table is written only in the two write-back states
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == ST_WRI || state_q == ST_WRJ)
		else $error("table write outside write-back");

	// A result is loaded only when the output register is free
	a_oreg: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !out_ready |=> ovalid_q && $stable(obyte_q))
		else $error("pending result overwritten");

endmodule

// ===== tb/rc4_stream_cipher_checker.sv =====
// Scoreboard for rc4_stream_cipher: watches the input and output channels, predicts
// every result word from its own copy of the permutation state, and compares fields.
// Depends on rc4sc_pkg.
module rc4_stream_cipher_checker
	import rc4sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  cmd_t       cmd,
	input  logic [7:0] byte_in,
	input  logic       last_in,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] byte_out,
	input  logic       last_out,
	input  logic       key_incomplete,
	output int         fail_count,
	output int         pending,
	output int         results_checked
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       incomplete;
	} cipher_word_t;

	// Predicted permutation; an entry never written reads as its own index
	logic [7:0]   sbox [256];
	logic         sbox_written [256];
	logic [7:0]   ptr_i;
	logic [7:0]   ptr_j;
	logic [8:0]   key_count;
	cipher_word_t expected_words [$];
	cipher_word_t oldest;

	function automatic logic [7:0] sbox_read(input logic [7:0] a);
		return sbox_written[a] ? sbox[a] : a;
	endfunction

	task automatic sbox_swap(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] va;
		logic [7:0] vb;
		va = sbox_read(a);
		vb = sbox_read(b);
		sbox[a] = vb;
		sbox_written[a] = 1'b1;
		sbox[b] = va;
		sbox_written[b] = 1'b1;
	endtask

	// Back to the identity permutation with counters cleared
	task automatic cipher_restart();
		for (int k = 0; k < 256; k++) begin
			sbox[k] = 8'h00;
			sbox_written[k] = 1'b0;
		end
		ptr_i = 8'h00;
		ptr_j = 8'h00;
		key_count = 9'd0;
	endtask

	// Advance the predicted state by one accepted word; queue a result for data words
	task automatic cipher_predict(input cmd_t c, input logic [7:0] b, input logic l);
		logic [7:0] t;
		logic [7:0] ks;
		case (c)
			CMD_RESTART: begin
				cipher_restart();
			end
			CMD_KEY: begin
				if (key_count < KEY_LENGTH) begin
					ptr_j = ptr_j + sbox_read(ptr_i) + b;
					sbox_swap(ptr_i, ptr_j);
					ptr_i = ptr_i + 8'd1;
					key_count = key_count + 9'd1;
					// key just completed: indices start over for the keystream
					if (key_count >= KEY_LENGTH) begin
						ptr_i = 8'h00;
						ptr_j = 8'h00;
					end
				end
			end
			CMD_DATA: begin
				if (key_count < KEY_LENGTH) begin
					// no key yet: byte goes through untouched, flagged
					expected_words.push_back('{data: b, last: l, incomplete: 1'b1});
				end else begin
					ptr_i = ptr_i + 8'd1;
					ptr_j = ptr_j + sbox_read(ptr_i);
					sbox_swap(ptr_i, ptr_j);
					t = sbox_read(ptr_i) + sbox_read(ptr_j);
					ks = sbox_read(t);
					expected_words.push_back('{data: b ^ ks, last: l, incomplete: 1'b0});
				end
			end
			default: begin
				// unused code, nothing happens
			end
		endcase
	endtask

	// Output side first: a word leaving at this edge always stems from an earlier input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_restart();
			expected_words.delete();
			fail_count = 0;
			pending = 0;
			results_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word: byte_out %02h last_out %0b key_incomplete %0b",
						byte_out, last_out, key_incomplete);
					fail_count++;
				end else begin
					oldest = expected_words.pop_front();
					results_checked++;
					if (byte_out !== oldest.data) begin
						$error("byte_out: expected %02h, got %02h", oldest.data, byte_out);
						fail_count++;
					end
					if (last_out !== oldest.last) begin
						$error("last_out: expected %0b, got %0b", oldest.last, last_out);
						fail_count++;
					end
					if (key_incomplete !== oldest.incomplete) begin
						$error("key_incomplete: expected %0b, got %0b",
							oldest.incomplete, key_incomplete);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				cipher_predict(cmd, byte_in, last_in);
			pending = expected_words.size();
		end
	end

endmodule

// ===== tb/rc4_stream_cipher_tb.sv =====
// Testbench top for rc4_stream_cipher: clock, reset, word stimulus and output stalls.
// Depends on rc4sc_pkg, rc4_stream_cipher and rc4_stream_cipher_checker.
module rc4_stream_cipher_tb;
	import rc4sc_pkg::*;

	localparam int KEY_LEN      = int'(KEY_LENGTH);
	localparam int ITEM_TARGET  = 1200;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 20;
	localparam int CYCLE_LIMIT  = 200000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	cmd_t       cmd;
	logic [7:0] byte_in;
	logic       last_in;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] byte_out;
	logic       last_out;
	logic       key_incomplete;

	int fail_count;
	int pending;
	int results_checked;
	int cycle_count = 0;

	// Stimulus bookkeeping
	int  key_sent;
	int  data_sent;
	int  restart_sent;
	int  unused_sent;
	int  extra_keys;
	int  long_holds;
	bit  send_burst;
	bit  recv_burst;

	rc4_stream_cipher u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.byte_in        (byte_in),
		.last_in        (last_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.byte_out       (byte_out),
		.last_out       (last_out),
		.key_incomplete (key_incomplete)
	);

	rc4_stream_cipher_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.byte_in         (byte_in),
		.last_in         (last_in),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.byte_out        (byte_out),
		.last_out        (last_out),
		.key_incomplete  (key_incomplete),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d result words outstanding",
				cycle_count, pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Offer one word after a random gap; valid stays high across back-to-back words
	task automatic send_word(input cmd_t c, input logic [7:0] b, input logic l);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		byte_in  <= b;
		last_in  <= l;
		do @(posedge clk); while (!in_ready);
		case (c)
			CMD_KEY:     key_sent++;
			CMD_DATA:    data_sent++;
			CMD_RESTART: restart_sent++;
			default:     unused_sent++;
		endcase
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic some_last();
		return ($urandom_range(0, 5) == 0);
	endfunction

	// Receiver: random hold-offs, bursts with none, and two long stalls to fill the block
	initial begin : receiver
		int gap;
		int taken;
		out_ready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_burst = !recv_burst;
			gap = recv_burst ? 0 : $urandom_range(0, 7);
			if (taken == 30 || taken == 300) begin
				gap = HOLD_CYCLES;
				long_holds++;
			end
			@(negedge clk);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		int  session_no;
		int  n_key;
		int  n_data;
		int  key_style;
		int  remaining;
		bit  well_formed;
		logic [7:0] kb;

		in_valid = 1'b0;
		cmd = CMD_NONE;
		byte_in = 8'h00;
		last_in = 1'b0;
		arst_n = 1'b0;
		key_sent = 0;
		data_sent = 0;
		restart_sent = 0;
		unused_sent = 0;
		extra_keys = 0;
		long_holds = 0;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		session_no = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: data before any key, unused code, a self-swap, restart
		send_word(CMD_DATA, 8'h00, 1'b0);
		send_word(CMD_DATA, 8'hFF, 1'b1);
		send_word(CMD_NONE, 8'hA5, 1'b1);
		send_word(CMD_KEY, 8'h00, 1'b0);     // j stays 0: entry 0 swapped with itself
		send_word(CMD_KEY, 8'hFF, 1'b1);
		send_word(CMD_DATA, 8'h5A, 1'b0);    // key still partial
		send_word(CMD_RESTART, 8'hFF, 1'b1);
		send_word(CMD_DATA, 8'hC3, 1'b1);
		send_word(CMD_NONE, 8'h00, 1'b0);

		// Random sessions: mostly restart + full key + data, some cut short
		while (key_sent + data_sent + restart_sent - extra_keys < ITEM_TARGET) begin
			remaining = ITEM_TARGET - (key_sent + data_sent + restart_sent - extra_keys);
			// a full key only when the word budget still has room for it
			well_formed = ((session_no == 0) || ($urandom_range(0, 4) != 0)) &&
				(remaining > KEY_LEN + 40);
			send_word(CMD_RESTART, any_byte(), 1'($urandom_range(0, 1)));
			if (well_formed) begin
				key_style = $urandom_range(0, 7);
				for (int k = 0; k < KEY_LEN; k++) begin
					kb = (key_style == 0) ? 8'h00 : (key_style == 1) ? 8'hFF : any_byte();
					send_word(CMD_KEY, kb, 1'($urandom_range(0, 1)));
				end
				n_data = (session_no == 0) ? 150 : $urandom_range(40, 150);
				if (n_data > remaining - KEY_LEN - 1)
					n_data = remaining - KEY_LEN - 1;
				for (int k = 0; k < n_data; k++) begin
					// occasional noise: surplus key byte or unused code
					if ($urandom_range(0, 19) == 0) begin
						if ($urandom_range(0, 1) == 1) begin
							send_word(CMD_KEY, any_byte(), 1'($urandom_range(0, 1)));
							extra_keys++;
						end else begin
							send_word(CMD_NONE, any_byte(), 1'($urandom_range(0, 1)));
						end
					end
					send_word(CMD_DATA, any_byte(), some_last());
				end
			end else begin
				n_key = (KEY_LEN > 1) ? $urandom_range(1, KEY_LEN - 1) : 0;
				if (n_key > remaining / 2)
					n_key = remaining / 2;
				n_data = $urandom_range(5, 20);
				if (n_data > remaining - n_key - 1)
					n_data = remaining - n_key - 1;
				for (int k = 0; k < n_key; k++)
					send_word(CMD_KEY, any_byte(), 1'($urandom_range(0, 1)));
				for (int k = 0; k < n_data; k++)
					send_word(CMD_DATA, any_byte(), some_last());
			end
			session_no++;
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain, then let the block settle
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("Covered %0d sessions: %0d key, %0d data, %0d restart, %0d unused-code words.",
			session_no, key_sent, data_sent, restart_sent, unused_sent);
		$display("%0d result words compared, %0d surplus key bytes, %0d long output stalls.",
			results_checked, extra_keys, long_holds);
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rc4sc_pkg.sv
rtl/rc4_stream_cipher.sv
tb/rc4_stream_cipher_checker.sv
tb/rc4_stream_cipher_tb.sv
